// File: design/chroma_qp_table_builder_assert.svh
// Assertion macros shared by the chroma QP table builder modules.
// Synthesis builds see empty bodies.
`ifndef CHROMA_QP_TABLE_BUILDER_ASSERT_SVH
`define CHROMA_QP_TABLE_BUILDER_ASSERT_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define CQTB_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("chroma QP table builder: assertion failed");

// The expression must never be true outside reset.
`define CQTB_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("chroma QP table builder: forbidden condition seen");

`else

`define CQTB_ASSERT(lbl, clk, rst_n, prop)
`define CQTB_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// File: design/cqtb_pkg.sv
`timescale 1ns / 1ps

package cqtb_pkg;

    // Largest legal QP value and table index.
    localparam logic [5:0] QP_MAX           = 6'd63;
    localparam logic [5:0] PIVOT_ORIGIN_RST = 6'd26;

    // One pivot transaction.
    typedef struct packed {
        logic [5:0] step_minus_one;
        logic [5:0] diff_value;
        logic       last_point;
    } t_item;

    // One emitted table entry.
    typedef struct packed {
        logic [5:0] entry_index;
        logic [5:0] mapped_qp;
        logic       overflow_flag;
        logic       last_entry;
    } t_result;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic new_run;
        logic init_step;
        logic piv_step;
        logic div_step;
        logic seg_step;
        logic tail_step;
        logic emit_step;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic init_done;
        logic cursor_full;
        logic div_done;
        logic seg_done;
        logic tail_done;
        logic emit_done;
    } t_status;

endpackage

// File: design/cqtb_ctrl.sv
`timescale 1ns / 1ps
`include "chroma_qp_table_builder_assert.svh"

module cqtb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic             i_last_point,
    input  cqtb_pkg::t_status i_status,
    output logic             busy,
    output cqtb_pkg::t_cmd   o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INIT = 3'd1;
    localparam logic [2:0] S_PIV  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_SEG  = 3'd4;
    localparam logic [2:0] S_TAIL = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_loading, n_loading;
    logic       r_last, n_last;

    // Next-state and command decode.
    always_comb begin
        n_state   = r_state;
        n_loading = r_loading;
        n_last    = r_last;
        o_cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.accept  = 1'b1;
                    o_cmd.new_run = !r_loading;
                    n_loading     = 1'b1;
                    n_last        = i_last_point;
                    n_state       = r_loading ? S_PIV : S_INIT;
                end
            end
            S_INIT: begin
                o_cmd.init_step = 1'b1;
                if (i_status.init_done) begin
                    n_state = S_PIV;
                end
            end
            S_PIV: begin
                o_cmd.piv_step = 1'b1;
                if (i_status.cursor_full) begin
                    n_state = r_last ? S_TAIL : S_IDLE;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = S_SEG;
                end
            end
            S_SEG: begin
                o_cmd.seg_step = 1'b1;
                if (i_status.seg_done) begin
                    n_state = r_last ? S_TAIL : S_IDLE;
                end
            end
            S_TAIL: begin
                o_cmd.tail_step = 1'b1;
                if (i_status.tail_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.emit_step = 1'b1;
                if (i_status.emit_done) begin
                    n_state   = S_IDLE;
                    n_loading = 1'b0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_loading <= 1'b0;
            r_last    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_loading <= n_loading;
            r_last    <= n_last;
        end
    end

    assign busy = (r_state != S_IDLE);

    // A pivot that opens a run always fills the identity entries first.
    `CQTB_ASSERT(a_new_run_init, i_clk, i_rst_n, (r_state == S_IDLE && start && !r_loading) |=> (r_state == S_INIT))
    // The end of emission closes the run.
    `CQTB_ASSERT(a_emit_closes, i_clk, i_rst_n, (r_state == S_EMIT && i_status.emit_done) |=> (r_state == S_IDLE && !r_loading))
    // At most one datapath step is commanded per cycle.
    `CQTB_ASSERT(a_one_step, i_clk, i_rst_n, $onehot0({o_cmd.init_step, o_cmd.piv_step, o_cmd.div_step, o_cmd.seg_step, o_cmd.tail_step, o_cmd.emit_step}))

endmodule

// File: design/cqtb_dp.sv
`timescale 1ns / 1ps
`include "chroma_qp_table_builder_assert.svh"

module cqtb_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [5:0]        i_cfg_data,
    input  cqtb_pkg::t_item   i_item,
    input  cqtb_pkg::t_cmd    i_cmd,
    output cqtb_pkg::t_status o_status,
    output cqtb_pkg::t_result o_result,
    output logic              o_strobe
);

    // Control registers.
    logic [5:0] r_pivot_origin;
    logic [6:0] r_cnt;
    logic [6:0] r_cursor;
    logic       r_ovf;
    logic [2:0] r_dcnt;
    logic       r_out_vld;

    // Payload registers.
    logic [5:0] r_step_m1;
    logic [5:0] r_w;
    logic [5:0] r_base;
    logic [5:0] r_dsh;
    logic [6:0] r_rem;
    logic [5:0] r_quo;
    logic [6:0] r_acc_r;
    logic [6:0] r_acc_q;
    logic [5:0] r_rd_data;
    logic [5:0] r_out_idx;
    logic       r_out_last;

    logic [5:0] r_mem [64];

    logic [6:0] step;
    logic [6:0] seg_end;
    logic [6:0] rem_sh;
    logic       div_ge;
    logic [6:0] sum_r;
    logic       carry;
    logic [6:0] q_nx;
    logic [7:0] v_raw;
    logic       v_sat;
    logic [5:0] v_clip;
    logic [5:0] tail_v;
    logic       wr_en;
    logic [5:0] wr_addr;
    logic [5:0] wr_data;

    assign step    = {1'b0, r_step_m1} + 7'd1;
    assign seg_end = r_cursor + step;

    // Restoring divide step for delta / step, one quotient bit per cycle.
    assign rem_sh = {r_rem[5:0], r_dsh[5]};
    assign div_ge = (rem_sh >= step);

    // Running quotient and remainder of (delta * k + step / 2) / step.
    assign sum_r  = r_acc_r + r_rem;
    assign carry  = (sum_r >= step);
    assign q_nx   = r_acc_q + {1'b0, r_quo} + {6'd0, carry};
    assign v_raw  = {2'b00, r_base} + {1'b0, q_nx};
    assign v_sat  = (v_raw > {2'b00, cqtb_pkg::QP_MAX});
    assign v_clip = v_sat ? cqtb_pkg::QP_MAX : v_raw[5:0];

    // Tail entries are the previous entry plus one, clipped.
    assign tail_v = (r_base == cqtb_pkg::QP_MAX) ? cqtb_pkg::QP_MAX : r_base + 6'd1;

    // Status back to the controller.
    always_comb begin
        o_status.init_done   = (r_cnt == {1'b0, r_pivot_origin});
        o_status.cursor_full = r_cursor[6];
        o_status.div_done    = (r_dcnt == 3'd5);
        o_status.seg_done    = r_cnt[6] || (r_cnt == seg_end);
        o_status.tail_done   = r_cnt[6] || (r_cnt == 7'd63);
        o_status.emit_done   = (r_cnt[5:0] == 6'd63);
    end

    // Table write port select.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_cnt[5:0];
        wr_data = r_cnt[5:0];
        if (i_cmd.init_step) begin
            wr_en = 1'b1;
        end else if (i_cmd.seg_step) begin
            wr_en   = !r_cnt[6];
            wr_data = v_clip;
        end else if (i_cmd.tail_step) begin
            wr_en   = !r_cnt[6];
            wr_data = tail_v;
        end
    end

    // Table memory with a registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.emit_step) begin
            r_rd_data <= r_mem[r_cnt[5:0]];
        end
    end

    // Control state: configuration, index counter, cursor, overflow, divide counter, output strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pivot_origin <= cqtb_pkg::PIVOT_ORIGIN_RST;
            r_cnt          <= '0;
            r_cursor       <= '0;
            r_ovf          <= 1'b0;
            r_dcnt         <= '0;
            r_out_vld      <= 1'b0;
        end else begin
            r_out_vld <= i_cmd.emit_step;
            if (i_cfg_we) begin
                r_pivot_origin <= i_cfg_data;
            end
            if (i_cmd.accept && i_cmd.new_run) begin
                r_cnt <= '0;
            end
            if (i_cmd.init_step) begin
                if (o_status.init_done) begin
                    r_cursor <= {1'b0, r_pivot_origin};
                    r_ovf    <= 1'b0;
                end else begin
                    r_cnt <= r_cnt + 7'd1;
                end
            end
            if (i_cmd.piv_step) begin
                r_cnt  <= r_cursor + 7'd1;
                r_dcnt <= '0;
                if (r_cursor[6]) begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.div_step) begin
                r_dcnt <= r_dcnt + 3'd1;
            end
            if (i_cmd.seg_step) begin
                if (r_cnt[6]) begin
                    // Segment runs past the last index.
                    r_ovf    <= 1'b1;
                    r_cursor <= 7'd64;
                    r_cnt    <= 7'd65;
                end else begin
                    if (v_sat) begin
                        r_ovf <= 1'b1;
                    end
                    if (r_cnt == seg_end) begin
                        r_cursor <= seg_end;
                        r_cnt    <= seg_end + 7'd1;
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
            end
            if (i_cmd.tail_step) begin
                if (o_status.tail_done) begin
                    r_cnt <= '0;
                end else begin
                    r_cnt <= r_cnt + 7'd1;
                end
            end
            if (i_cmd.emit_step) begin
                r_cnt <= r_cnt + 7'd1;
            end
        end
    end

    // Payload: pivot fields, divider and interpolation accumulators, output entry.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_step_m1 <= i_item.step_minus_one;
            r_w       <= i_item.step_minus_one ^ i_item.diff_value;
        end
        if (i_cmd.init_step && o_status.init_done) begin
            r_base <= r_pivot_origin;
        end
        if (i_cmd.piv_step) begin
            r_rem   <= '0;
            r_quo   <= '0;
            r_dsh   <= r_w;
            r_acc_q <= '0;
            r_acc_r <= {1'b0, step[6:1]};
        end
        if (i_cmd.div_step) begin
            r_rem <= div_ge ? rem_sh - step : rem_sh;
            r_quo <= {r_quo[4:0], div_ge};
            r_dsh <= {r_dsh[4:0], 1'b0};
        end
        if (i_cmd.seg_step && !r_cnt[6]) begin
            r_acc_q <= q_nx;
            r_acc_r <= carry ? sum_r - step : sum_r;
            if (r_cnt == seg_end) begin
                r_base <= v_clip;
            end
        end
        if (i_cmd.tail_step && !r_cnt[6]) begin
            r_base <= tail_v;
        end
        if (i_cmd.emit_step) begin
            r_out_idx  <= r_cnt[5:0];
            r_out_last <= (r_cnt[5:0] == 6'd63);
        end
    end

    // Result transaction.
    always_comb begin
        o_result.entry_index   = r_out_idx;
        o_result.mapped_qp     = r_rd_data;
        o_result.overflow_flag = r_ovf;
        o_result.last_entry    = r_out_last;
    end
    assign o_strobe = r_out_vld;

    // The cursor never passes one beyond the last index.
    `CQTB_NEVER(a_cursor_range, i_clk, i_rst_n, r_cursor > 7'd64)
    // Entries after the first are emitted in consecutive cycles.
    `CQTB_ASSERT(a_emit_burst, i_clk, i_rst_n, (r_out_vld && r_out_idx != 6'd0) |-> $past(r_out_vld))
    // Interpolation remainders stay below the step.
    `CQTB_ASSERT(a_rem_bound, i_clk, i_rst_n, (i_cmd.seg_step && !r_cnt[6]) |-> (r_acc_r < step && r_rem < step))

endmodule

// File: design/chroma_qp_table_builder.sv
`timescale 1ns / 1ps
// Channel     Handshake                     Payload
// pivot in    start high, busy low          i_item (cqtb_pkg::t_item)
// entry out   o_strobe, one cycle each      o_result (cqtb_pkg::t_result)
// config      i_cfg_we                      i_cfg_data (pivot origin QP)
//
// A pivot keeps busy high for the pivot step, the divide and the segment fill (only the pivot
// step when the cursor is already at 64), plus the identity fill when it opens a run.
// A last pivot adds the tail fill (at least one step) and the emission of all 64 entries,
// one table entry per cycle from the table memory's registered read port.
// Reset is synchronous, loads the pivot origin with 26 and ends any run in progress.
// Results cannot be stalled; busy falls in the cycle the last entry is on the outputs.

module chroma_qp_table_builder (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  cqtb_pkg::t_item   i_item,
    output cqtb_pkg::t_result o_result,
    output logic              o_strobe,
    input  logic              i_cfg_we,
    input  logic [5:0]        i_cfg_data
);

    cqtb_pkg::t_cmd    cmd;
    cqtb_pkg::t_status status;

    // Sequencer for the run phases.
    cqtb_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_last_point (i_item.last_point),
        .i_status     (status),
        .busy         (busy),
        .o_cmd        (cmd)
    );

    // Table memory, divider and interpolation datapath.
    cqtb_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_item),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_result   (o_result),
        .o_strobe   (o_strobe)
    );

endmodule

// File: tb/sv/chroma_qp_table_checker.sv
`timescale 1ns / 1ps

// Watches the pivot, entry and config channels of the chroma QP table builder,
// rebuilds each table on its own, and compares every emitted entry in order.
module chroma_qp_table_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  cqtb_pkg::t_item   i_item,
    input  cqtb_pkg::t_result i_result,
    input  logic              i_strobe,
    input  logic              i_cfg_we,
    input  logic [5:0]        i_cfg_data,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_tables
);

    localparam int DEPTH = 64;

    // Shadow copy of the block's configuration and table-building state.
    logic [5:0] cfg_pivot_origin;
    logic [5:0] shadow_table [DEPTH];
    int         shadow_cursor;
    bit         run_open;
    bit         run_overflow;

    // Table entries still to come out, oldest first.
    cqtb_pkg::t_result expected_entries [$];

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        o_fail_count++;
    endtask

    // Folds one pivot into the shadow table; a last pivot queues the whole table.
    task automatic absorb_pivot(input cqtb_pkg::t_item pivot);
        int                step;
        int                delta;
        int                base;
        int                rounding;
        int                acc;
        int                seg_end;
        int                k;
        int                val;
        bit                seg_stop;
        cqtb_pkg::t_result entry;

        // The first pivot of a run lays down the identity part.
        if (!run_open) begin
            for (int j = 0; j <= int'(cfg_pivot_origin); j++) begin
                shadow_table[j] = j[5:0];
            end
            shadow_cursor = int'(cfg_pivot_origin);
            run_overflow  = 1'b0;
            run_open      = 1'b1;
        end

        step  = int'(pivot.step_minus_one) + 1;
        delta = int'(pivot.step_minus_one ^ pivot.diff_value);

        // A pivot arriving with a full table is dropped and only flags overflow.
        if (shadow_cursor >= DEPTH) begin
            run_overflow = 1'b1;
        end else begin
            base     = int'(shadow_table[shadow_cursor]);
            rounding = step >> 1;
            acc      = delta;
            seg_end  = shadow_cursor + step;
            k        = shadow_cursor + 1;
            seg_stop = 1'b0;
            while (!seg_stop && k <= seg_end) begin
                if (k >= DEPTH) begin
                    run_overflow = 1'b1;
                    seg_stop     = 1'b1;
                end else begin
                    val = base + (acc + rounding) / step;
                    if (val > int'(cqtb_pkg::QP_MAX)) begin
                        val          = int'(cqtb_pkg::QP_MAX);
                        run_overflow = 1'b1;
                    end
                    shadow_table[k] = val[5:0];
                    acc += delta;
                    k++;
                end
            end
            if (seg_end > DEPTH) begin
                seg_end = DEPTH;
            end
            shadow_cursor = seg_end;
        end

        // The last pivot fills the tail with clipped increments and emits everything.
        if (pivot.last_point) begin
            for (int j = shadow_cursor + 1; j < DEPTH; j++) begin
                val = int'(shadow_table[j - 1]) + 1;
                if (val > int'(cqtb_pkg::QP_MAX)) begin
                    val = int'(cqtb_pkg::QP_MAX);
                end
                shadow_table[j] = val[5:0];
            end
            for (int j = 0; j < DEPTH; j++) begin
                entry.entry_index   = j[5:0];
                entry.mapped_qp     = shadow_table[j];
                entry.overflow_flag = run_overflow;
                entry.last_entry    = (j == DEPTH - 1);
                expected_entries.push_back(entry);
            end
            run_open = 1'b0;
        end
    endtask

    initial begin
        o_fail_count     = 0;
        o_pending        = 0;
        o_tables         = 0;
        cfg_pivot_origin = cqtb_pkg::PIVOT_ORIGIN_RST;
        run_open         = 1'b0;
        run_overflow     = 1'b0;
        shadow_cursor    = 0;
        for (int j = 0; j < DEPTH; j++) begin
            shadow_table[j] = '0;
        end
    end

    // Everything is sampled at the rising edge, before the block's own updates land.
    always @(posedge i_clk) begin
        cqtb_pkg::t_result got;
        cqtb_pkg::t_result want;

        if (!i_rst_n) begin
            cfg_pivot_origin = cqtb_pkg::PIVOT_ORIGIN_RST;
            run_open         = 1'b0;
            run_overflow     = 1'b0;
            shadow_cursor    = 0;
            expected_entries.delete();
        end else begin
            // Compare an emitted entry against the oldest expectation.
            if (i_strobe) begin
                got = i_result;
                if (expected_entries.size() == 0) begin
                    report_mismatch($sformatf("unexpected entry index %0d qp %0d",
                                              got.entry_index, got.mapped_qp));
                end else begin
                    want = expected_entries.pop_front();
                    if (got.entry_index !== want.entry_index) begin
                        report_mismatch($sformatf("entry_index got %0d want %0d",
                                                  got.entry_index, want.entry_index));
                    end
                    if (got.mapped_qp !== want.mapped_qp) begin
                        report_mismatch($sformatf("mapped_qp at %0d got %0d want %0d",
                                                  want.entry_index, got.mapped_qp,
                                                  want.mapped_qp));
                    end
                    if (got.overflow_flag !== want.overflow_flag) begin
                        report_mismatch($sformatf("overflow_flag at %0d got %b want %b",
                                                  want.entry_index, got.overflow_flag,
                                                  want.overflow_flag));
                    end
                    if (got.last_entry !== want.last_entry) begin
                        report_mismatch($sformatf("last_entry at %0d got %b want %b",
                                                  want.entry_index, got.last_entry,
                                                  want.last_entry));
                    end
                    if (want.last_entry) begin
                        o_tables++;
                    end
                end
            end

            // A config write changes the value that the next run picks up.
            if (i_cfg_we) begin
                cfg_pivot_origin = i_cfg_data;
            end

            // A pivot transaction is taken when start is high and busy is low.
            if (i_start && !i_busy) begin
                absorb_pivot(i_item);
            end
        end
        o_pending <= expected_entries.size();
    end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    // Covers the longest single pivot with margin.
    localparam int SETTLE_CYCLES = 300;
    localparam int RANDOM_ITEMS  = 470;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    cqtb_pkg::t_item   item;
    cqtb_pkg::t_result result;
    logic              strobe;
    logic              cfg_we;
    logic [5:0]        cfg_data;

    int fail_count;
    int pending;
    int tables_seen;
    int pivots_sent;
    int cfg_writes;

    chroma_qp_table_builder dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (item),
        .o_result   (result),
        .o_strobe   (strobe),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    chroma_qp_table_checker checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (item),
        .i_result     (result),
        .i_strobe     (strobe),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_tables     (tables_seen)
    );

    // 2 ns clock.
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Idle gaps: mostly none or short, a few long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(20, 80);
    endfunction

    // Random pivot: short steps dominate so tables rarely fill up early.
    function automatic cqtb_pkg::t_item random_pivot(input bit last);
        cqtb_pkg::t_item p;
        if ($urandom_range(0, 9) < 7) begin
            p.step_minus_one = 6'($urandom_range(0, 12));
        end else begin
            p.step_minus_one = 6'($urandom_range(0, 63));
        end
        p.diff_value = 6'($urandom_range(0, 63));
        p.last_point = last;
        return p;
    endfunction

    function automatic cqtb_pkg::t_item make_pivot(input int step_m1, input int diff,
                                                   input bit last);
        cqtb_pkg::t_item p;
        p.step_minus_one = step_m1[5:0];
        p.diff_value     = diff[5:0];
        p.last_point     = last;
        return p;
    endfunction

    // Drive one pivot transaction after an optional idle gap and wait for its acceptance.
    task automatic send_pivot(input cqtb_pkg::t_item p);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= p;
        do @(posedge clk); while (busy);
        pivots_sent++;
    endtask

    // Write the pivot origin only once the block has drained and settled.
    task automatic write_pivot_origin(input logic [5:0] value);
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cfg_writes++;
    endtask

    function automatic logic [5:0] pick_pivot_origin();
        int roll;
        roll = $urandom_range(0, 3);
        if (roll == 0) begin
            return 6'd0;
        end else if (roll == 1) begin
            return cqtb_pkg::QP_MAX;
        end
        return 6'($urandom_range(0, 63));
    endfunction

    // Main stimulus.
    initial begin
        int run_len;
        int random_sent;

        pivots_sent = 0;
        cfg_writes  = 0;
        start    <= 1'b0;
        item     <= '0;
        cfg_we   <= 1'b0;
        cfg_data <= '0;
        rst_n    <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Pivot origin from reset, a single flat pivot.
        send_pivot(make_pivot(0, 0, 1'b1));

        // Start at zero; one full-width step runs one entry past the end.
        write_pivot_origin(6'd0);
        send_pivot(make_pivot(63, 0, 1'b1));

        // Start at the top; all-ones pivot overflows at once, no tail left.
        write_pivot_origin(cqtb_pkg::QP_MAX);
        send_pivot(make_pivot(63, 63, 1'b1));

        // Interpolation saturation on the second pivot.
        write_pivot_origin(6'd0);
        send_pivot(make_pivot(0, 63, 1'b0));
        send_pivot(make_pivot(0, 63, 1'b1));

        // Table full after the first pivot: later pivots are dropped.
        send_pivot(make_pivot(63, 63, 1'b0));
        send_pivot(make_pivot(5, 17, 1'b0));
        send_pivot(make_pivot(2, 40, 1'b1));

        // Steep segment so that the tail clips at 63 without flagging.
        send_pivot(make_pivot(1, 63, 1'b1));

        // A config write in the middle of a run only affects the next run.
        write_pivot_origin(6'd10);
        send_pivot(make_pivot(4, 3, 1'b0));
        write_pivot_origin(6'd40);
        send_pivot(make_pivot(7, 42, 1'b1));
        send_pivot(make_pivot(3, 21, 1'b1));

        // A few exact fits and odd steps at mid start.
        write_pivot_origin(6'd31);
        send_pivot(make_pivot(15, 10, 1'b0));
        send_pivot(make_pivot(15, 20, 1'b0));
        send_pivot(make_pivot(0, 0, 1'b1));
        send_pivot(make_pivot(31, 0, 1'b1));

        // Random runs of pivots, each closed by a last pivot.
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 7) == 0) begin
                write_pivot_origin(pick_pivot_origin());
            end
            if ($urandom_range(0, 9) == 0) begin
                run_len = $urandom_range(8, 14);
            end else begin
                run_len = $urandom_range(1, 5);
            end
            for (int n = 1; n < run_len; n++) begin
                send_pivot(random_pivot(1'b0));
                random_sent++;
                if ($urandom_range(0, 39) == 0) begin
                    write_pivot_origin(pick_pivot_origin());
                end
            end
            send_pivot(random_pivot(1'b1));
            random_sent++;
        end

        // Drain, then let the block settle before judging.
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d pivots, checked %0d tables, %0d pivot origin writes.",
                 pivots_sent, tables_seen, cfg_writes);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Hard stop in case the block hangs.
    initial begin
        #2000000;
        $display("Timeout: block stopped making progress.");
        $display("TEST FAILED");
        $finish;
    end

endmodule
